// ===== rtl/tisf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tisf_pkg
// Shared types, telnet byte codes and parse step function for the telnet
// command stripper.
// ============================================================================
package tisf_pkg;

    // Telnet command bytes
    localparam logic [7:0] TN_IAC = 8'd255;
    localparam logic [7:0] TN_SB  = 8'd250;
    localparam logic [7:0] TN_SE  = 8'd240;

    // Parse state codes
    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] ST_NORMAL = 3'd0;
    localparam logic [ST_W-1:0] ST_IAC    = 3'd1;
    localparam logic [ST_W-1:0] ST_OPT    = 3'd2;
    localparam logic [ST_W-1:0] ST_SB     = 3'd3;
    localparam logic [ST_W-1:0] ST_SB_IAC = 3'd4;

    // One byte beat between stages
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } beat_t;

    // Outcome of parsing one byte
    typedef struct packed {
        logic [ST_W-1:0] next_state;
        logic            emit;
    } step_t;

    function automatic step_t parse_step(input logic [ST_W-1:0] state,
                                         input logic [7:0] b);
        step_t r;
        r.next_state = state;
        r.emit       = 1'b0;
        unique case (state)
            ST_IAC:
            begin
                if (b == TN_IAC)
                begin
                    r.emit       = 1'b1;
                    r.next_state = ST_NORMAL;
                end
                else if (b == TN_SB)
                begin
                    r.next_state = ST_SB;
                end
                else
                begin
                    r.next_state = ST_OPT;
                end
            end
            ST_OPT:
            begin
                r.next_state = ST_NORMAL;
            end
            ST_SB:
            begin
                if (b == TN_IAC)
                begin
                    r.next_state = ST_SB_IAC;
                end
            end
            ST_SB_IAC:
            begin
                if (b == TN_SE)
                begin
                    r.next_state = ST_NORMAL;
                end
                else if (b != TN_IAC)
                begin
                    r.next_state = ST_SB;
                end
            end
            default:
            begin
                // Plain data; unused codes behave the same way
                if (b == TN_IAC)
                begin
                    r.next_state = ST_IAC;
                end
                else
                begin
                    r.emit       = 1'b1;
                    r.next_state = ST_NORMAL;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tisf_in_reg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tisf_in_reg
// Input register: captures one received byte per beat and holds it until
// the parser takes it.
// ============================================================================
module tisf_in_reg
    import tisf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output beat_t      held,
    input  logic       take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Accept when empty or when the held beat leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_byte;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

// ===== rtl/tisf_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tisf_parser
// Telnet parse state machine: decodes the held byte, drops command bytes
// and forwards data bytes to the result register.
// ============================================================================
module tisf_parser
    import tisf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  beat_t held,
    output logic  take,
    output beat_t result,
    input  logic  result_ready
);

    logic [ST_W-1:0] parse_state_reg;
    logic [ST_W-1:0] parse_state_next;
    step_t           step;

    // Decode the held byte against the current state
    assign step = parse_step(parse_state_reg, held.data);

    // Advance when nothing is emitted or the result register has room
    assign take          = held.valid && (!step.emit || result_ready);
    assign result.valid  = held.valid && step.emit;
    assign result.data   = held.data;

    assign parse_state_next = take ? step.next_state : parse_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg <= ST_NORMAL;
        end
        else
        begin
            parse_state_reg <= parse_state_next;
        end
    end

endmodule

// ===== rtl/tisf_out_reg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tisf_out_reg
// Result register: holds one data byte until the downstream side takes it.
// ============================================================================
module tisf_out_reg
    import tisf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  beat_t      result,
    output logic       result_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // Room when empty or when the current beat drains this cycle
    assign result_ready = !valid_reg || out_ready;
    assign load         = result.valid && result_ready;
    assign valid_next   = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.data;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg;

endmodule

// ===== rtl/telnet_iac_stream_filter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// telnet_iac_stream_filter
// Strips telnet IAC command sequences from a received byte stream.
// ============================================================================
// Takes one byte per beat and sustains one byte per clock cycle while no
// stall holds the input. A byte passes through an input register, is
// decoded by the telnet parse state machine, and any resulting data byte
// lands in an output register. Data bytes pass unchanged, IAC IAC yields
// one 255, IAC SB through IAC SE is dropped, and IAC with any other
// command drops that byte and one option byte. Partial sequences carry
// over between beats; the input keeps accepting while a result waits at
// the output, and only a full output register that is not draining, with a
// pending data byte, stalls the input.
module telnet_iac_stream_filter
    import tisf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    beat_t held;
    beat_t result;
    logic  take;
    logic  result_ready;

    tisf_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .held     (held),
        .take     (take)
    );

    tisf_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .held         (held),
        .take         (take),
        .result       (result),
        .result_ready (result_ready)
    );

    tisf_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .result_ready (result_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte)
    );

endmodule
